[src/nstp_pkg.sv]
// nstp_pkg: types, constants and helpers for the nested self-time profiler
// used by every module under src
package nstp_pkg;

  localparam int unsigned NumIds     = 32;
  localparam int unsigned StackDepth = 16;
  localparam int unsigned TimeBits   = 48;
  localparam int unsigned IdW        = 5;
  localparam int unsigned SpW        = 4;
  localparam int unsigned DepthW     = 5;
  localparam int unsigned QDepth     = 2;

  typedef enum logic [2:0] {
    CMD_BEGIN   = 3'd0,
    CMD_BEGIN_X = 3'd1,
    CMD_END     = 3'd2,
    CMD_FRAME   = 3'd3,
    CMD_READ    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_UNDERFLOW= 2'd2,
    ST_NOPARENT = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  func_id;
    logic [47:0] timestamp;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] duration;
    logic [31:0] func_frame_count;
    logic [63:0] func_frame_time;
    logic [63:0] func_total_count;
    logic [63:0] func_total_time;
    logic [63:0] frame_sum;
    logic [63:0] total_sum;
    logic [4:0]  stack_depth;
  } out_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP_NAMED,
    OP_POP_EXT,
    OP_FRAME,
    OP_REPORT
  } op_e;

  // back-end sequencer states
  typedef enum logic [1:0] {B_IDLE, B_RD, B_SWEEP, B_OUT} bst_e;

  typedef struct packed {
    op_e              op;
    logic [1:0]       status;
    logic [IdW-1:0]   id;
    logic [IdW-1:0]   sel;
    logic [47:0]      duration;
    logic             top_level;
    logic [DepthW-1:0] depth;
  } job_t;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

[src/nested_self_time_profiler_top.sv]
// nested_self_time_profiler_top: region stack front, job queue, statistics back
// depends on nstp_pkg, nstp_front, nstp_queue, nstp_back
// latency: each beat passes the job queue and the back-end states IDLE, RD and OUT, with SWEEP for frame reset
// frame reset walks all 32 ids through the statistics memories, one id per cycle
// throughput: set by the back-end sequencer, which takes the next job only after the last result beat is loaded
// reset clears the stack depth, all statistics and sums, and the queue
module nested_self_time_profiler_top import nstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // front pushes a classified job per accepted beat
  logic job_valid, q_full, q_empty, q_pop;
  job_t job, q_job;

  nstp_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .job_valid_o(job_valid), .job_full_i(q_full), .job_o(job)
  );

  nstp_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_valid), .push_data_i(job),
    .full_o(q_full), .empty_o(q_empty), .pop_i(q_pop), .pop_data_o(q_job)
  );

  // back applies statistics updates and registers the result beat
  nstp_back u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .pop_o(q_pop), .job_i(q_job),
    .out_valid, .out_stall, .out_data
  );

endmodule

[src/nstp_front.sv]
// nstp_front: accepts events, runs the region stack, computes durations
// depends on nstp_pkg
module nstp_front import nstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic job_valid_o,
  input  logic job_full_i,
  output job_t job_o
);

  logic [IdW-1:0]      ids_q   [StackDepth];
  logic                ext_q   [StackDepth];
  logic [TimeBits-1:0] times_q [StackDepth];
  logic [DepthW-1:0]   depth_q, depth_d;
  logic [SpW-1:0]      top, par;
  logic [TimeBits-1:0] dur;
  logic                acc;
  job_t                job;

  assign in_stall    = job_full_i;
  assign acc         = in_valid && !job_full_i;
  assign job_valid_o = acc;
  assign job_o       = job;
  assign top = SpW'(depth_q - 1'b1);
  assign par = SpW'(depth_q - 2'd2);
  assign dur = in_data.timestamp - times_q[top];

  always_comb begin
    depth_d = depth_q;
    job = '0;
    job.id = in_data.func_id;
    job.sel = in_data.func_id;
    job.op = OP_REPORT;
    job.status = ST_OK;
    case (in_data.cmd)
      CMD_BEGIN, CMD_BEGIN_X: begin
        if (depth_q == DepthW'(StackDepth)) job.status = ST_OVERFLOW;
        else depth_d = depth_q + 1'b1;
      end
      CMD_END: begin
        if (depth_q == '0) job.status = ST_UNDERFLOW;
        else begin
          depth_d = depth_q - 1'b1;
          job.duration = dur;
          job.top_level = (depth_d == '0);
          if (ext_q[top]) begin
            job.op = OP_POP_EXT;
            if (depth_d == '0) job.status = ST_NOPARENT;
          end else begin
            job.op = OP_POP_NAMED;
            job.id = ids_q[top];
          end
        end
      end
      CMD_FRAME: job.op = OP_FRAME;
      default: ;
    endcase
    job.depth = depth_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) depth_q <= '0;
    else if (acc) depth_q <= depth_d;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if ((in_data.cmd == CMD_BEGIN || in_data.cmd == CMD_BEGIN_X)
          && depth_q != DepthW'(StackDepth)) begin
        ids_q[SpW'(depth_q)]   <= in_data.func_id;
        ext_q[SpW'(depth_q)]   <= (in_data.cmd == CMD_BEGIN_X);
        times_q[SpW'(depth_q)] <= in_data.timestamp;
      end
      if (in_data.cmd == CMD_END && depth_q > DepthW'(1) && ext_q[top])
        times_q[par] <= times_q[par] + dur;
    end
  end

endmodule

[src/nstp_queue.sv]
// nstp_queue: short fifo of classified jobs between front and back
// depends on nstp_pkg
module nstp_queue import nstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  job_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

endmodule

[src/nstp_back.sv]
// nstp_back: per-id statistics memories, frame fold sweep and result register
// depends on nstp_pkg
module nstp_back import nstp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic empty_i,
  output logic pop_o,
  input  job_t job_i,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [31:0] fc_q [NumIds];
  logic [63:0] ft_q [NumIds];
  logic [63:0] tc_q [NumIds];
  logic [63:0] tt_q [NumIds];
  logic [NumIds-1:0] fv_q, tv_q;   // entry written since reset
  logic [63:0] fsum_q, tsum_q;
  bst_e        st_q, st_d;
  job_t        job_q;
  logic [IdW-1:0] sw_q;
  logic [31:0] rfc; logic [63:0] rft, rtc, rtt;
  out_t        res_q;
  logic        ov_q;
  logic        ld;

  assign rfc = fv_q[job_q.sel] ? fc_q[job_q.sel] : '0;
  assign rft = fv_q[job_q.sel] ? ft_q[job_q.sel] : '0;
  assign rtc = tv_q[job_q.sel] ? tc_q[job_q.sel] : '0;
  assign rtt = tv_q[job_q.sel] ? tt_q[job_q.sel] : '0;

  // result register free: load the new beat
  assign ld = (st_q == B_OUT) && (!ov_q || !out_stall);

  assign out_valid = ov_q;
  assign out_data  = res_q;

  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE: if (!empty_i) st_d = (job_i.op == OP_FRAME) ? B_SWEEP : B_RD;
      B_SWEEP: if (sw_q == IdW'(NumIds - 1)) st_d = B_RD;
      B_RD: st_d = B_OUT;
      B_OUT: if (!ov_q || !out_stall) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  assign pop_o = (st_q == B_IDLE) && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE; ov_q <= 1'b0; fv_q <= '0; tv_q <= '0;
      fsum_q <= '0; tsum_q <= '0; sw_q <= '0;
    end else begin
      st_q <= st_d;
      if (ld) ov_q <= 1'b1;
      else if (ov_q && !out_stall) ov_q <= 1'b0;
      if (pop_o && job_i.op == OP_FRAME) begin
        tsum_q <= sat_add64(tsum_q, fsum_q);
        fsum_q <= '0;
        sw_q <= '0;
      end
      if (st_q == B_SWEEP) begin
        tv_q[sw_q] <= 1'b1;
        fv_q[sw_q] <= 1'b1;
        sw_q <= sw_q + 1'b1;
      end
      if (pop_o && job_i.op == OP_POP_NAMED) begin
        fv_q[job_i.id] <= 1'b1;
        if (job_i.top_level) fsum_q <= sat_add64(fsum_q, 64'(job_i.duration));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (pop_o && job_i.op == OP_POP_NAMED) begin
      fc_q[job_i.id] <= !fv_q[job_i.id] ? 32'd1 :
                        (&fc_q[job_i.id]) ? fc_q[job_i.id] : fc_q[job_i.id] + 1'b1;
      ft_q[job_i.id] <= sat_add64(fv_q[job_i.id] ? ft_q[job_i.id] : '0,
                                  64'(job_i.duration));
    end
    if (st_q == B_SWEEP) begin
      tc_q[sw_q] <= sat_add64(tv_q[sw_q] ? tc_q[sw_q] : '0,
                              64'(fv_q[sw_q] ? fc_q[sw_q] : '0));
      tt_q[sw_q] <= sat_add64(tv_q[sw_q] ? tt_q[sw_q] : '0,
                              fv_q[sw_q] ? ft_q[sw_q] : '0);
      fc_q[sw_q] <= '0;
      ft_q[sw_q] <= '0;
    end
    if (ld) begin
      res_q.status           <= job_q.status;
      res_q.duration         <= job_q.duration;
      res_q.func_frame_count <= rfc;
      res_q.func_frame_time  <= rft;
      res_q.func_total_count <= rtc;
      res_q.func_total_time  <= rtt;
      res_q.frame_sum        <= fsum_q;
      res_q.total_sum        <= tsum_q;
      res_q.stack_depth      <= job_q.depth;
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking bench for nested_self_time_profiler_top
// depends on nstp_pkg and the profiler rtl; keeps its own model of stack and statistics
module tb_top;
  import nstp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #6 clk_i = ~clk_i;

  nested_self_time_profiler_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
  localparam int WATCHDOG = 20000;

  // profiler model state
  logic [4:0]  stk_id [StackDepth];
  logic        stk_ext [StackDepth];
  logic [47:0] stk_t0 [StackDepth];
  int          depth;
  logic [31:0] frm_cnt [NumIds];
  logic [63:0] frm_tim [NumIds];
  logic [63:0] tot_cnt [NumIds];
  logic [63:0] tot_tim [NumIds];
  logic [63:0] frame_acc, total_acc;

  out_t pending_results[$];
  int   n_err = 0, n_checked = 0, idle_cnt = 0;
  int   n_sent = 0;
  int   send_idle_pct = 0, stall_pct = 0;
  bit   hold_off = 1'b0;
  bit   timed_out = 1'b0;

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic void clear_profile();
    depth = 0;
    frame_acc = '0;
    total_acc = '0;
    for (int i = 0; i < NumIds; i++) begin
      frm_cnt[i] = '0; frm_tim[i] = '0; tot_cnt[i] = '0; tot_tim[i] = '0;
    end
  endfunction

  // apply one event to the model, return the stats beat it should produce
  function automatic out_t profile_event(in_t ev);
    out_t r;
    logic [4:0] sel;
    logic [4:0] id;
    logic [31:0] c1;
    r = '0;
    sel = ev.func_id;
    case (ev.cmd)
      CMD_BEGIN, CMD_BEGIN_X: begin
        if (depth >= StackDepth) r.status = ST_OVERFLOW;
        else begin
          stk_id[depth] = sel;
          stk_ext[depth] = (ev.cmd == CMD_BEGIN_X);
          stk_t0[depth] = ev.timestamp;
          depth++;
        end
      end
      CMD_END: begin
        if (depth == 0) r.status = ST_UNDERFLOW;
        else begin
          depth--;
          id = stk_id[depth];
          r.duration = ev.timestamp - stk_t0[depth];
          if (!stk_ext[depth]) begin
            c1 = frm_cnt[id] + 32'd1;
            if (c1 != 32'd0) frm_cnt[id] = c1;
            frm_tim[id] = add_sat(frm_tim[id], {16'd0, r.duration});
            if (depth == 0) frame_acc = add_sat(frame_acc, {16'd0, r.duration});
          end else if (depth == 0) begin
            r.status = ST_NOPARENT;
          end else begin
            stk_t0[depth-1] = stk_t0[depth-1] + r.duration;
          end
        end
      end
      CMD_FRAME: begin
        for (int i = 0; i < NumIds; i++) begin
          tot_cnt[i] = add_sat(tot_cnt[i], {32'd0, frm_cnt[i]});
          tot_tim[i] = add_sat(tot_tim[i], frm_tim[i]);
          frm_cnt[i] = '0;
          frm_tim[i] = '0;
        end
        total_acc = add_sat(total_acc, frame_acc);
        frame_acc = '0;
      end
      default: ;
    endcase
    r.func_frame_count = frm_cnt[sel];
    r.func_frame_time  = frm_tim[sel];
    r.func_total_count = tot_cnt[sel];
    r.func_total_time  = tot_tim[sel];
    r.frame_sum        = frame_acc;
    r.total_sum        = total_acc;
    r.stack_depth      = depth[4:0];
    return r;
  endfunction

  // drive one beat and hold it until accepted; model applied at acceptance
  task automatic send_beat(in_t ev, bit chk_fixed, logic [1:0] fx_st, logic [47:0] fx_dur,
                           logic [4:0] fx_dep);
    out_t exp_r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    exp_r = profile_event(ev);
    // typed-in expectations for the obvious rows
    if (chk_fixed && (exp_r.status != fx_st || exp_r.duration != fx_dur ||
                      exp_r.stack_depth != fx_dep)) begin
      n_err++;
      if (n_err <= 10)
        $display("directed row mismatch: cmd %0d status %0d/%0d dur %0h/%0h depth %0d/%0d",
                 ev.cmd, fx_st, exp_r.status, fx_dur, exp_r.duration, fx_dep,
                 exp_r.stack_depth);
    end
    pending_results.push_back(exp_r);
    n_sent++;
  endtask

  function automatic in_t mk(cmd_e c, logic [4:0] id, logic [47:0] ts);
    in_t e;
    e.cmd = c; e.func_id = id; e.timestamp = ts;
    return e;
  endfunction

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        out_t e;
        e = pending_results.pop_front();
        n_checked++;
        if (out_data !== e) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch on beat %0d", n_checked);
            $display("  expected %p", e);
            $display("  actual   %p", out_data);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt == WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("watchdog expired, %0d results outstanding", pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  typedef struct {
    in_t ev;
    bit fixed;
    logic [1:0] st;
    logic [47:0] dur;
    logic [4:0] dep;
  } row_t;

  task automatic random_phase(int n_items, int idle_p, int stall_p);
    logic [47:0] ts;
    in_t ev;
    int r;
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    ts = 48'({$urandom, $urandom});
    for (int k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      ts = ts + 48'($urandom_range(5000));
      if ($urandom_range(19) == 0) ts = 48'({$urandom, $urandom});
      ev.func_id = 5'($urandom);
      ev.timestamp = ts;
      // mostly well-formed nesting, some underflow/overflow/noise
      if (r < 35) ev.cmd = ($urandom_range(3) == 0) ? CMD_BEGIN_X : CMD_BEGIN;
      else if (r < 75) ev.cmd = CMD_END;
      else if (r < 80) ev.cmd = CMD_FRAME;
      else if (r < 95) ev.cmd = CMD_READ;
      else ev.cmd = 3'($urandom_range(7));
      if (depth == 0 && r >= 35 && r < 75 && $urandom_range(3) != 0) ev.cmd = CMD_BEGIN;
      send_beat(ev, 1'b0, '0, '0, '0);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    row_t rows[$];
    clear_profile();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty end, timestamp extremes, wrap, external nesting, ids, unknown commands, overflow, frame reset
    rows.push_back('{mk(CMD_END, 5'd0, 48'd0), 1, ST_UNDERFLOW, 48'd0, 5'd0});
    rows.push_back('{mk(CMD_READ, 5'd31, TMAX), 1, ST_OK, 48'd0, 5'd0});
    rows.push_back('{mk(CMD_BEGIN, 5'd31, TMAX), 1, ST_OK, 48'd0, 5'd1});
    rows.push_back('{mk(CMD_END, 5'd31, 48'd9), 1, ST_OK, 48'd10, 5'd0});
    rows.push_back('{mk(CMD_BEGIN, 5'd1, 48'd100), 1, ST_OK, 48'd0, 5'd1});
    rows.push_back('{mk(CMD_BEGIN_X, 5'd2, 48'd150), 1, ST_OK, 48'd0, 5'd2});
    rows.push_back('{mk(CMD_END, 5'd0, 48'd170), 1, ST_OK, 48'd20, 5'd1});
    rows.push_back('{mk(CMD_END, 5'd1, 48'd200), 1, ST_OK, 48'd80, 5'd0});
    rows.push_back('{mk(CMD_BEGIN_X, 5'd3, 48'd0), 1, ST_OK, 48'd0, 5'd1});
    rows.push_back('{mk(CMD_END, 5'd3, TMAX), 1, ST_NOPARENT, TMAX, 5'd0});
    rows.push_back('{mk(CMD_READ, 5'd1, 48'd0), 0, '0, '0, '0});
    rows.push_back('{mk(CMD_FRAME, 5'd1, 48'd0), 0, '0, '0, '0});
    rows.push_back('{mk(CMD_READ, 5'd31, 48'd0), 0, '0, '0, '0});
    rows.push_back('{mk(cmd_e'(3'd5), 5'd21, 48'h5555_5555_5555), 0, '0, '0, '0});
    rows.push_back('{mk(cmd_e'(3'd7), 5'd10, 48'hAAAA_AAAA_AAAA), 0, '0, '0, '0});
    for (int i = 0; i < StackDepth; i++)
      rows.push_back('{mk(CMD_BEGIN, 5'(i), 48'(i * 1000)), 1, ST_OK, 48'd0, 5'(i + 1)});
    rows.push_back('{mk(CMD_BEGIN_X, 5'd9, 48'd0), 1, ST_OVERFLOW, 48'd0, 5'd16});
    for (int i = StackDepth; i > 0; i--)
      rows.push_back('{mk(CMD_END, 5'd0, 48'd50000), 0, '0, '0, '0});
    rows.push_back('{mk(CMD_FRAME, 5'd0, 48'd0), 0, '0, '0, '0});

    foreach (rows[i]) send_beat(rows[i].ev, rows[i].fixed, rows[i].st, rows[i].dur,
                                rows[i].dep);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    random_phase(120, 0, 0);
    random_phase(100, 86, 0);
    random_phase(100, 0, 86);
    random_phase(100, 8, 8);

    // back-pressure: receiver holds off while sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(80, 0, 0);
    join

    repeat (60) @(posedge clk_i);
    $display("run covered %0d events, %0d result beats checked, nesting to depth %0d",
             n_sent, n_checked, StackDepth);
    $display("phases: directed, free flow, sparse sender, heavy stall, mixed, held output");
    if (n_err == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_err);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
